// ===== hdl/rsds_pkg.sv =====
// Shared types, codes and constants of the ray-sphere depth scan.
package rsds_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic REG_MAX_RANGE   = 1'b0;
  localparam logic REG_OBST_COUNT  = 1'b1;

  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_START = 39797;
  localparam int SQRT_STEPS   = 23;
  localparam int REM_W        = 46;
  localparam int PROJ_W       = 29;

  // One rotation cell's state.
  typedef struct packed {
    logic               vld;
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [17:0] z;
  } rsds_rot_t;

  // One square-root cell's state, with the candidate it belongs to.
  typedef struct packed {
    logic                     vld;
    logic                     ok;
    logic signed [PROJ_W-1:0] proj;
    logic [REM_W-1:0]         rem;
    logic [REM_W-1:0]         root;
  } rsds_sq_t;

  // Arctangent of 2^-step in angle units (full circle = 65536).
  function automatic logic [13:0] atan_step(input int step);
    logic [13:0] a;
    case (step)
      0:       a = 14'd8192;
      1:       a = 14'd4836;
      2:       a = 14'd2555;
      3:       a = 14'd1297;
      4:       a = 14'd651;
      5:       a = 14'd326;
      6:       a = 14'd163;
      7:       a = 14'd81;
      8:       a = 14'd41;
      9:       a = 14'd20;
      10:      a = 14'd10;
      11:      a = 14'd5;
      12:      a = 14'd3;
      13:      a = 14'd1;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/rsds_cordic_cell.sv =====
// One registered rotation step of the direction chain.
module rsds_cordic_cell
  import rsds_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  rsds_rot_t a,
  output rsds_rot_t q
);

  logic signed [18:0] xs;
  logic signed [18:0] ys;
  logic signed [17:0] ang;

  assign xs  = a.x >>> STEP;
  assign ys  = a.y >>> STEP;
  assign ang = $signed(18'(atan_step(STEP)));

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= a.vld;
    end
    if (a.z >= 0) begin
      q.x <= a.x - ys;
      q.y <= a.y + xs;
      q.z <= a.z - ang;
    end else begin
      q.x <= a.x + ys;
      q.y <= a.y - xs;
      q.z <= a.z + ang;
    end
  end

endmodule

// ===== hdl/rsds_sqrt_cell.sv =====
// One registered root-bit step of the integer square-root chain.
module rsds_sqrt_cell
  import rsds_pkg::*;
#(
  parameter int BITPOS = 44
) (
  input  logic     clk,
  input  logic     rst,
  input  rsds_sq_t a,
  output rsds_sq_t q
);

  logic [REM_W-1:0] bitv;
  logic [REM_W-1:0] trial;

  assign bitv  = REM_W'(1) << BITPOS;
  assign trial = a.root + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else begin
      q.vld <= a.vld;
    end
    q.ok   <= a.ok;
    q.proj <= a.proj;
    if (a.rem >= trial) begin
      q.rem  <= a.rem - trial;
      q.root <= (a.root >> 1) + bitv;
    end else begin
      q.rem  <= a.rem;
      q.root <= a.root >> 1;
    end
  end

endmodule

// ===== hdl/ray_sphere_depth_scan.sv =====
// Top level of the ray-sphere depth scan: obstacle table, scan pipeline and control.
//
// The block keeps a table of spheres written by load items and, for each cast
// item, returns the nearest positive entry distance along a horizontal ray, or
// max_range with hit low when nothing closer is met. A load item writes one
// table entry and gives no result. A cast item first runs its angle through a
// chain of 14 rotation cells, then streams one table entry per cycle through
// the geometry pipeline and a chain of 23 square-root cells, and finally waits
// for the pipeline to empty; the number of entries scanned is obstacle_count,
// capped at MAX_OBSTACLES. The result then turns valid as soon as a previous
// result has been taken, in the same cycle that the next item can be accepted.
// The table port reads one entry per cycle, which sets the scan length. One
// cast is worked on at a time; a finished result sits in the output register
// while the next item is already accepted. Entries that were never written
// read as anything, so obstacle_count should cover written entries only.
module ray_sphere_depth_scan
  import rsds_pkg::*;
#(
  parameter int MAX_OBSTACLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               op,
  input  logic [5:0]         entry_index,
  input  logic signed [23:0] obst_x,
  input  logic signed [23:0] obst_y,
  input  logic signed [23:0] obst_z,
  input  logic [22:0]        obst_radius,
  input  logic signed [23:0] origin_x,
  input  logic signed [23:0] origin_y,
  input  logic signed [23:0] origin_z,
  input  logic [15:0]        ray_angle,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [22:0]        distance,
  output logic               hit
);

  localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CW = $clog2(MAX_OBSTACLES + 1);
  localparam int DRAIN_CYCLES = 34;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIR   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Configuration registers.
  logic [22:0] max_range;
  logic [6:0]  obstacle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range      <= 23'd51200;
      obstacle_count <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_RANGE:  max_range      <= cfg_data;
        REG_OBST_COUNT: obstacle_count <= cfg_data[6:0];
      endcase
    end
  end

  // Control.
  logic [2:0]    state;
  logic [CW-1:0] scan_cnt;
  logic [CW-1:0] scan_n;
  logic [5:0]    drain_cnt;
  logic          cmd_accept;
  logic          scan_issue;
  logic          neg;
  logic signed [23:0] ox;
  logic signed [23:0] oy;
  logic signed [23:0] oz;
  logic signed [18:0] cosv;
  logic signed [18:0] sinv;
  logic [22:0]   best;
  logic          hit_acc;

  assign cmd_ready  = (state == ST_IDLE);
  assign cmd_accept = cmd_valid && cmd_ready;
  assign scan_n     = (32'(obstacle_count) > 32'(MAX_OBSTACLES)) ?
                      CW'(MAX_OBSTACLES) : CW'(obstacle_count);
  assign scan_issue = (state == ST_SCAN) && (scan_cnt < scan_n);

  // The angle is folded into the right half plane; the result is negated later.
  logic signed [17:0] z_raw;
  logic signed [17:0] z_fold;
  logic               fold;
  rsds_rot_t          rot [CORDIC_STEPS+1];

  assign z_raw = 18'($signed(ray_angle));
  always_comb begin
    fold   = 1'b0;
    z_fold = z_raw;
    if (z_raw > 18'sd16384) begin
      z_fold = z_raw - 18'sd32768;
      fold   = 1'b1;
    end else if (z_raw < -18'sd16384) begin
      z_fold = z_raw + 18'sd32768;
      fold   = 1'b1;
    end
  end

  assign rot[0].vld = cmd_accept && (op == OP_CAST);
  assign rot[0].x   = 19'(CORDIC_START);
  assign rot[0].y   = 19'sd0;
  assign rot[0].z   = z_fold;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    rsds_cordic_cell #(.STEP(k)) u_cell (
      .clk (clk),
      .rst (rst),
      .a   (rot[k]),
      .q   (rot[k+1])
    );
  end

  // Obstacle table, one write and one read per cycle.
  logic signed [23:0] mem_x [MAX_OBSTACLES];
  logic signed [23:0] mem_y [MAX_OBSTACLES];
  logic signed [23:0] mem_z [MAX_OBSTACLES];
  logic [22:0]        mem_r [MAX_OBSTACLES];
  logic signed [23:0] rd_x;
  logic signed [23:0] rd_y;
  logic signed [23:0] rd_z;
  logic [22:0]        rd_r;
  logic               load_we;

  assign load_we = cmd_accept && (op == OP_LOAD) &&
                   (32'(entry_index) < 32'(MAX_OBSTACLES));

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_x[AW'(entry_index)] <= obst_x;
      mem_y[AW'(entry_index)] <= obst_y;
      mem_z[AW'(entry_index)] <= obst_z;
      mem_r[AW'(entry_index)] <= obst_radius;
    end
    rd_x <= mem_x[scan_cnt[AW-1:0]];
    rd_y <= mem_y[scan_cnt[AW-1:0]];
    rd_z <= mem_z[scan_cnt[AW-1:0]];
    rd_r <= mem_r[scan_cnt[AW-1:0]];
  end

  // Geometry pipeline, one candidate per cycle.
  logic               rd_vld, s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld;
  logic signed [24:0] s1_dx, s1_dy, s1_dz;
  logic [22:0]        s1_r;
  logic signed [43:0] s2_pxc, s2_pys;
  logic signed [24:0] s2_dx, s2_dy, s2_dz;
  logic [22:0]        s2_r;
  logic signed [PROJ_W-1:0] s3_proj;
  logic signed [24:0] s3_dx, s3_dy, s3_dz;
  logic [22:0]        s3_r;
  logic signed [47:0] s4_cp, s4_sp;
  logic signed [PROJ_W-1:0] s4_proj;
  logic signed [24:0] s4_dx, s4_dy, s4_dz;
  logic [22:0]        s4_r;
  logic signed [29:0] s5_ex, s5_ey;
  logic [49:0]        s5_dz2;
  logic [45:0]        s5_r2;
  logic signed [PROJ_W-1:0] s5_proj;
  logic [59:0]        s6_ex2, s6_ey2;
  logic [49:0]        s6_dz2;
  logic [45:0]        s6_r2;
  logic signed [PROJ_W-1:0] s6_proj;
  logic [60:0]        s7_d2;
  logic [45:0]        s7_r2;
  logic signed [PROJ_W-1:0] s7_proj;
  logic signed [44:0] dot;
  logic signed [32:0] ex_full, ey_full;
  rsds_sq_t           sq [SQRT_STEPS+1];

  assign dot     = 45'(s2_pxc) + 45'(s2_pys);
  assign ex_full = 33'(s4_dx) - 33'(s4_cp[47:16]);
  assign ey_full = 33'(s4_dy) - 33'(s4_sp[47:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      s1_vld <= rd_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx <= 25'(rd_x) - 25'(ox);
    s1_dy <= 25'(rd_y) - 25'(oy);
    s1_dz <= 25'(rd_z) - 25'(oz);
    s1_r  <= rd_r;

    s2_pxc <= 44'(s1_dx) * 44'(cosv);
    s2_pys <= 44'(s1_dy) * 44'(sinv);
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_dz  <= s1_dz;
    s2_r   <= s1_r;

    s3_proj <= dot[44:16];
    s3_dx   <= s2_dx;
    s3_dy   <= s2_dy;
    s3_dz   <= s2_dz;
    s3_r    <= s2_r;

    s4_cp   <= 48'(cosv) * 48'(s3_proj);
    s4_sp   <= 48'(sinv) * 48'(s3_proj);
    s4_proj <= s3_proj;
    s4_dx   <= s3_dx;
    s4_dy   <= s3_dy;
    s4_dz   <= s3_dz;
    s4_r    <= s3_r;

    // The residuals stay below 2^28 in magnitude, so 30 bits hold them exactly.
    s5_ex   <= ex_full[29:0];
    s5_ey   <= ey_full[29:0];
    s5_dz2  <= 50'($unsigned(50'(s4_dz) * 50'(s4_dz)));
    s5_r2   <= 46'(s4_r) * 46'(s4_r);
    s5_proj <= s4_proj;

    s6_ex2  <= 60'($unsigned(60'(s5_ex) * 60'(s5_ex)));
    s6_ey2  <= 60'($unsigned(60'(s5_ey) * 60'(s5_ey)));
    s6_dz2  <= s5_dz2;
    s6_r2   <= s5_r2;
    s6_proj <= s5_proj;

    s7_d2   <= 61'(s6_ex2) + 61'(s6_ey2) + 61'(s6_dz2);
    s7_r2   <= s6_r2;
    s7_proj <= s6_proj;

    if (rst) begin
      sq[0].vld <= 1'b0;
    end else begin
      sq[0].vld <= s7_vld;
    end
    sq[0].ok   <= (s7_proj > 0) && (s7_d2 <= 61'(s7_r2));
    sq[0].proj <= s7_proj;
    sq[0].rem  <= s7_r2 - s7_d2[45:0];
    sq[0].root <= '0;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rsds_sqrt_cell #(.BITPOS(REM_W - 2 - 2 * k)) u_cell (
      .clk (clk),
      .rst (rst),
      .a   (sq[k]),
      .q   (sq[k+1])
    );
  end

  // Running minimum over the candidates leaving the root chain.
  logic signed [PROJ_W:0] entry;
  logic                   better;

  assign entry  = (PROJ_W+1)'(sq[SQRT_STEPS].proj) -
                  $signed((PROJ_W+1)'(sq[SQRT_STEPS].root[22:0]));
  assign better = sq[SQRT_STEPS].vld && sq[SQRT_STEPS].ok && (entry > 0) &&
                  (entry < $signed((PROJ_W+1)'(best)));

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      ox  <= origin_x;
      oy  <= origin_y;
      oz  <= origin_z;
      neg <= fold;
    end
    if (state == ST_DIR && rot[CORDIC_STEPS].vld) begin
      cosv <= neg ? -rot[CORDIC_STEPS].x : rot[CORDIC_STEPS].x;
      sinv <= neg ? -rot[CORDIC_STEPS].y : rot[CORDIC_STEPS].y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      drain_cnt <= '0;
      best      <= '0;
      hit_acc   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // A new result replaces a taken one in the same cycle.
      if (state == ST_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (better) begin
        best    <= entry[22:0];
        hit_acc <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_accept && op == OP_CAST) begin
            state <= ST_DIR;
          end
        end
        ST_DIR: begin
          if (rot[CORDIC_STEPS].vld) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
            best     <= max_range;
            hit_acc  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            state     <= ST_DRAIN;
            drain_cnt <= '0;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == 6'(DRAIN_CYCLES - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res_valid || res_ready)) begin
      distance <= best;
      hit      <= hit_acc;
    end
  end

  // The direction chain only delivers while a cast waits for it.
  a_rot_dir: assert property (@(posedge clk) disable iff (rst)
    rot[CORDIC_STEPS].vld |-> state == ST_DIR)
    else $error("direction result outside the direction phase");

  // Candidates only leave the root chain while a scan or drain is running.
  a_sq_phase: assert property (@(posedge clk) disable iff (rst)
    sq[SQRT_STEPS].vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("candidate outside the scan");

  // The running minimum never rises above the range during a drain.
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> best <= max_range)
    else $error("minimum above range");

  // A hit always means a distance strictly below the range.
  a_hit_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && hit_acc) |-> best < max_range)
    else $error("hit without a closer entry");

  // The scan address never runs past the scan length.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt <= scan_n)
    else $error("scan address past count");

endmodule

// ===== test/tb_ray_sphere_depth_scan.sv =====
// Self-checking testbench for the ray-sphere depth scan: obstacle loads, ray casts, range settings.
module tb_ray_sphere_depth_scan
  import rsds_pkg::*;
();

  // Sizes and limits of the run.
  localparam int TABLE_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  // Rotation table of the direction generator, in angle steps.
  localparam int DIR_STEPS = 14;
  localparam longint DIR_ATAN [DIR_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                              41, 20, 10, 5, 3, 1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_MAX_RANGE;
  logic [22:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic op = OP_LOAD;
  logic [5:0] entry_index = '0;
  logic signed [23:0] obst_x = '0;
  logic signed [23:0] obst_y = '0;
  logic signed [23:0] obst_z = '0;
  logic [22:0] obst_radius = '0;
  logic signed [23:0] origin_x = '0;
  logic signed [23:0] origin_y = '0;
  logic signed [23:0] origin_z = '0;
  logic [15:0] ray_angle = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [22:0] distance;
  logic hit;

  always #5 clk = ~clk;

  ray_sphere_depth_scan i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .op(op), .entry_index(entry_index),
    .obst_x(obst_x), .obst_y(obst_y), .obst_z(obst_z), .obst_radius(obst_radius),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z), .ray_angle(ray_angle),
    .res_valid(res_valid), .res_ready(res_ready),
    .distance(distance), .hit(hit)
  );

  // The testbench's own copy of the obstacle table and registers.
  longint sph_x [TABLE_DEPTH];
  longint sph_y [TABLE_DEPTH];
  longint sph_z [TABLE_DEPTH];
  longint sph_r [TABLE_DEPTH];
  logic [22:0] range_reg;
  logic [6:0] count_reg;

  typedef struct {
    logic [22:0] distance;
    logic hit;
  } depth_t;

  depth_t depth_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint root, bit_v;
    root = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - (root + bit_v);
        root = (root >>> 1) + bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return root;
  endfunction

  // Nearest sphere entry along the ray, worked out from the local table.
  function automatic depth_t nearest_depth(logic [15:0] ang, longint ox, longint oy, longint oz);
    depth_t d;
    longint z, x, y, xs, ys, c, s, best, dx, dy, dz, proj, ex, ey, d2, r2, entry;
    bit fold;
    int n;
    z = longint'($signed(ang));
    fold = 1'b0;
    x = 39797;
    y = 0;
    if (z > 16384) begin
      z -= 32768;
      fold = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      fold = 1'b1;
    end
    for (int i = 0; i < DIR_STEPS; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= DIR_ATAN[i];
      end else begin
        x += ys; y -= xs; z += DIR_ATAN[i];
      end
    end
    c = fold ? -x : x;
    s = fold ? -y : y;
    best = range_reg;
    d.hit = 1'b0;
    n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
    for (int i = 0; i < n; i++) begin
      dx = sph_x[i] - ox;
      dy = sph_y[i] - oy;
      dz = sph_z[i] - oz;
      proj = floor_shr(dx * c + dy * s, 16);
      if (proj > 0) begin
        ex = dx - floor_shr(c * proj, 16);
        ey = dy - floor_shr(s * proj, 16);
        d2 = ex * ex + ey * ey + dz * dz;
        r2 = sph_r[i] * sph_r[i];
        if (d2 <= r2) begin
          entry = proj - int_sqrt(r2 - d2);
          if (entry > 0 && entry < best) begin
            best = entry;
            d.hit = 1'b1;
          end
        end
      end
    end
    d.distance = best[22:0];
    return d;
  endfunction

  // Each accepted result is checked against the oldest expected depth.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (depth_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: distance %0d hit %0d", distance, hit);
      end else begin
        depth_t e;
        e = depth_q.pop_front();
        if (e.distance !== distance || e.hit !== hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Depth mismatch: expected %0d/%0d, got %0d/%0d",
                     e.distance, e.hit, distance, hit);
        end
      end
    end
  end

  // The receiver stalls on its own pattern; some phases never stall.
  int stall_mode = 0;
  always @(negedge clk) begin
    case (stall_mode)
      0: res_ready <= 1'b1;
      1: res_ready <= ($urandom_range(0, 3) != 0);
      default: res_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // The watchdog ends a run in which nothing is accepted for too long.
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [22:0] value);
    cmd_valid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_RANGE) range_reg = value;
    else count_reg = value[6:0];
  endtask

  // Sends one item, with a random gap between bursts; the expectation is
  // formed when the item is taken. Valid stays high into the next item of a
  // burst and is dropped by whatever comes next otherwise.
  task automatic send_item(logic is_cast, logic [5:0] idx, logic signed [23:0] a,
                           logic signed [23:0] b, logic signed [23:0] c, logic [22:0] r,
                           logic [15:0] ang);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_valid <= 1'b1;
    op <= is_cast ? OP_CAST : OP_LOAD;
    entry_index <= idx;
    obst_x <= a; obst_y <= b; obst_z <= c; obst_radius <= r;
    origin_x <= a; origin_y <= b; origin_z <= c;
    ray_angle <= ang;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    if (is_cast) begin
      depth_q.push_back(nearest_depth(ang, a, b, c));
    end else begin
      sph_x[idx] = a; sph_y[idx] = b; sph_z[idx] = c; sph_r[idx] = r;
    end
    @(negedge clk);
  endtask

  task automatic load_sphere(int idx, logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, logic [22:0] r);
    send_item(1'b0, idx[5:0], x, y, z, r, 16'($urandom()));
  endtask

  task automatic cast_ray(logic signed [23:0] x, logic signed [23:0] y,
                          logic signed [23:0] z, logic [15:0] ang);
    send_item(1'b1, 6'($urandom()), x, y, z, 23'($urandom()), ang);
  endtask

  // Waits until every result is in and the block has gone quiet.
  task automatic drain;
    cmd_valid <= 1'b0;
    while (depth_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Small random coordinate around a center, so that rays do meet spheres.
  function automatic logic signed [23:0] near(int span);
    return 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Directed cases: extremes, empty table, spheres along each axis, origin inside.
  task automatic test_directed;
    cast_ray(24'sh7fffff, -24'sh800000, 0, 16'h0000);
    load_sphere(0, 24'sd2560, 0, 0, 23'd256);
    load_sphere(1, 0, 24'sd2560, 0, 23'd512);
    load_sphere(2, -24'sd2560, 0, 0, 23'd256);
    load_sphere(3, 0, -24'sd2560, 0, 23'd256);
    load_sphere(4, 24'sd512, 0, 24'sd100, 23'd2000);
    load_sphere(5, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 23'h7fffff);
    load_sphere(6, -24'sh800000, -24'sh800000, -24'sh800000, 23'h7fffff);
    load_sphere(63, 24'sd1000, 24'sd1000, 0, 23'd0);
    drain();
    write_reg(REG_OBST_COUNT, 23'd5);
    cast_ray(0, 0, 0, 16'h0000);
    cast_ray(0, 0, 0, 16'h4000);
    cast_ray(0, 0, 0, 16'h8000);
    cast_ray(0, 0, 0, 16'hc000);
    cast_ray(0, 0, 0, 16'h7fff);
    cast_ray(0, 0, 0, 16'hffff);
    cast_ray(24'sd512, 0, 24'sd100, 16'h0000);
    cast_ray(0, 0, 24'sd9000, 16'h0000);
    drain();
    write_reg(REG_OBST_COUNT, 23'd7);
    cast_ray(0, 0, 0, 16'h2000);
    cast_ray(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 16'h2001);
    drain();
  endtask

  // Fill the table completely, then cast beyond-table counts and range extremes.
  task automatic test_full_table;
    for (int i = 0; i < TABLE_DEPTH; i++)
      load_sphere(i, near(8000), near(8000), near(800), 23'($urandom_range(0, 3000)));
    load_sphere($urandom_range(0, 63), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                23'($urandom()));
    drain();
    write_reg(REG_OBST_COUNT, 23'd127);
    write_reg(REG_MAX_RANGE, 23'h7fffff);
    repeat (20) cast_ray(near(2000), near(2000), near(400), 16'($urandom()));
    drain();
    write_reg(REG_MAX_RANGE, 23'd0);
    write_reg(REG_OBST_COUNT, 23'd64);
    repeat (8) cast_ray(near(2000), near(2000), near(400), 16'($urandom()));
    drain();
    write_reg(REG_OBST_COUNT, 23'd0);
    write_reg(REG_MAX_RANGE, 23'd51200);
    repeat (4) cast_ray(24'($urandom()), 24'($urandom()), 24'($urandom()), 16'($urandom()));
    drain();
  endtask

  // Random phases: mostly nearby geometry so that hits are common, some
  // full-range noise so that every bit of each field toggles.
  task automatic test_random;
    logic signed [23:0] a, b, c;
    int idx;
    for (int phase = 0; phase < 6; phase++) begin
      stall_mode = phase % 3;
      write_reg(REG_OBST_COUNT, 23'($urandom_range(1, 64)));
      write_reg(REG_MAX_RANGE, (phase == 5) ? 23'h7fffff : 23'($urandom_range(1000, 60000)));
      for (int k = 0; k < 250; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          a = 24'($urandom()); b = 24'($urandom()); c = 24'($urandom());
        end else begin
          a = near(6000); b = near(6000); c = near(600);
        end
        if ($urandom_range(0, 3) == 0) begin
          idx = $urandom_range(0, 63);
          load_sphere(idx, a, b, c, ($urandom_range(0, 9) == 0) ? 23'($urandom()) :
                      23'($urandom_range(0, 4000)));
        end else begin
          cast_ray(a, b, c, 16'($urandom()));
        end
      end
      drain();
    end
  endtask

  initial begin
    // The local copy of the table is cleared first; casts only ever scan
    // entries that a load has written.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sph_x[i] = 0; sph_y[i] = 0; sph_z[i] = 0; sph_r[i] = 0;
    end
    range_reg = 23'd51200;
    count_reg = 7'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rsds_pkg.sv
hdl/rsds_cordic_cell.sv
hdl/rsds_sqrt_cell.sv
hdl/ray_sphere_depth_scan.sv
test/tb_ray_sphere_depth_scan.sv
